// File: rtl/prat_pkg.sv
// ----------------------------------------------------------------------------
// prat_pkg
// Shared types and constants of the prime residue admissibility tracker:
// payload structs, command and status codes, prime and reciprocal tables.
// ----------------------------------------------------------------------------
package prat_pkg;

  // field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned OffsetW = 9;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DepthW  = 7;
  localparam int unsigned LimitW  = 10;
  localparam int unsigned MaskW   = 61;
  localparam int unsigned PrimeW  = 6;
  localparam int unsigned RecipW  = 16;
  localparam int unsigned TableLen = 18;

  // register reset value
  localparam logic [LimitW-1:0] LimitReset = 10'd61;

  // command codes
  localparam logic [CmdW-1:0] CmdRestart = 2'd0;
  localparam logic [CmdW-1:0] CmdPush    = 2'd1;
  localparam logic [CmdW-1:0] CmdPop     = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] StatDone      = 2'd0;
  localparam logic [StatusW-1:0] StatRejected  = 2'd1;
  localparam logic [StatusW-1:0] StatStackFull = 2'd2;
  localparam logic [StatusW-1:0] StatEmpty     = 2'd3;

  // tracked primes in ascending order
  localparam logic [PrimeW-1:0] PrimeTable [TableLen] = '{
    6'd2,  6'd3,  6'd5,  6'd7,  6'd11, 6'd13, 6'd17, 6'd19, 6'd23,
    6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53, 6'd59, 6'd61
  };

  // floor(2^16 / prime), quotient estimate is low by at most one
  localparam logic [RecipW-1:0] RecipTable [TableLen] = '{
    16'd32768, 16'd21845, 16'd13107, 16'd9362, 16'd5957, 16'd5041,
    16'd3855,  16'd3449,  16'd2849,  16'd2259, 16'd2114, 16'd1771,
    16'd1598,  16'd1524,  16'd1394,  16'd1236, 16'd1110, 16'd1074
  };

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [OffsetW-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DepthW-1:0]  depth;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StHold
  } state_e;

endpackage

// File: rtl/prime_residue_admissibility_tracker.sv
// ----------------------------------------------------------------------------
// prime_residue_admissibility_tracker
// Per-prime residue masks of accepted offsets with a snapshot stack in memory.
// ----------------------------------------------------------------------------
// flow: an accepted item is registered, executes in StExec and loads its result
//   into the output register when it is free, else it waits in StHold
// items are taken only in StIdle, after the last result is loaded; the stack read
//   and the first of the two constant-prime residue steps register with the item
// reset: masks hold bit zero only, depth 1, prime_limit 61; the snapshot
//   memory is not cleared and needs no clearing pass
module prime_residue_admissibility_tracker #(
  parameter int unsigned MAX_DEPTH  = 64,
  parameter int unsigned NUM_PRIMES = 18
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  prat_pkg::in_item_t       in_data_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output prat_pkg::out_item_t      out_data_o,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [prat_pkg::LimitW-1:0] cfg_data_i
);
  import prat_pkg::*;

  localparam int unsigned AddrW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef logic [NUM_PRIMES-1:0][MaskW-1:0] masks_t;

  // control state
  state_e             state_q, state_d;
  logic [LimitW-1:0]  limit_q;
  logic [DepthW-1:0]  held_q, held_d;
  masks_t             masks_q, masks_d;
  logic               out_valid_q;
  out_item_t          out_data_q;

  // item registers
  logic [CmdW-1:0]    cmd_q;
  logic [OffsetW-1:0] offset_q;
  logic [NUM_PRIMES-1:0][OffsetW-1:0] quo_q, quo_d;
  out_item_t          res_q, res_c, res_sel;

  // snapshot stack
  masks_t             stack_mem [MAX_DEPTH];
  masks_t             rd_q;
  logic               mem_we;
  logic [AddrW-1:0]   wr_addr, rd_addr;

  // lane results
  masks_t                 next_masks;
  logic [NUM_PRIMES-1:0]  fills;

  logic in_xfer, cfg_xfer, slot_free, out_load, exec_en;

  assign in_xfer   = in_valid_i & ~in_stall_o;
  assign cfg_xfer  = cfg_valid_i & cfg_ready_o;
  assign slot_free = ~out_valid_q | ~out_stall_i;

  // per-prime residue lanes
  for (genvar g = 0; g < NUM_PRIMES; g++) begin : g_lane
    logic [OffsetW+RecipW-1:0] qmul;
    logic [OffsetW+PrimeW-1:0] qprod;
    logic [OffsetW-1:0]        diff;
    logic [6:0]                rem;
    logic [MaskW-1:0]          bit_m, full_m, mark_m;
    logic                      tracked, newly;

    // quotient estimate from the incoming offset
    assign qmul     = (OffsetW+RecipW)'(in_data_i.offset) *
                      (OffsetW+RecipW)'(RecipTable[g]);
    assign quo_d[g] = qmul[OffsetW+RecipW-1:RecipW];

    // remainder with one correction step
    assign qprod = (OffsetW+PrimeW)'(quo_q[g]) * (OffsetW+PrimeW)'(PrimeTable[g]);
    assign diff  = offset_q - qprod[OffsetW-1:0];
    assign rem   = (diff >= OffsetW'(PrimeTable[g])) ?
                   7'(diff - OffsetW'(PrimeTable[g])) : diff[6:0];

    // mark residue and check for a full mask
    assign bit_m   = MaskW'(1) << rem;
    assign full_m  = (MaskW'(1) << PrimeTable[g]) - MaskW'(1);
    assign mark_m  = masks_q[g] | bit_m;
    assign tracked = (LimitW'(PrimeTable[g]) <= limit_q);
    assign newly   = ((masks_q[g] & bit_m) == '0);
    assign fills[g]      = tracked & newly & (mark_m == full_m);
    assign next_masks[g] = tracked ? mark_m : masks_q[g];
  end

  assign wr_addr = AddrW'(held_q - DepthW'(1));
  assign rd_addr = AddrW'(held_q - DepthW'(2));

  // command execution
  always_comb begin
    masks_d    = masks_q;
    held_d     = held_q;
    mem_we     = 1'b0;
    res_c.status = StatDone;
    unique case (cmd_q)
      CmdRestart: begin
        for (int i = 0; i < NUM_PRIMES; i++) begin
          masks_d[i] = MaskW'(1);
        end
        held_d = DepthW'(1);
      end
      CmdPush: begin
        if (held_q >= DepthW'(MAX_DEPTH)) begin
          res_c.status = StatStackFull;
        end else if (|fills) begin
          res_c.status = StatRejected;
        end else begin
          mem_we  = exec_en;
          masks_d = next_masks;
          held_d  = held_q + DepthW'(1);
        end
      end
      CmdPop: begin
        if (held_q <= DepthW'(1)) begin
          res_c.status = StatEmpty;
        end else begin
          masks_d = rd_q;
          held_d  = held_q - DepthW'(1);
        end
      end
      default: begin
      end
    endcase
    res_c.depth = held_d;
  end

  assign res_sel = (state_q == StExec) ? res_c : res_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_xfer) state_d = StExec;
      StExec: state_d = slot_free ? StIdle : StHold;
      StHold: if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    exec_en     = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o  = cfg_valid_i;
        cfg_ready_o = 1'b1;
      end
      StExec: begin
        exec_en  = 1'b1;
        out_load = slot_free;
      end
      StHold: begin
        out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      limit_q     <= LimitReset;
      held_q      <= DepthW'(1);
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PRIMES; i++) begin
        masks_q[i] <= MaskW'(1);
      end
    end else begin
      state_q <= state_d;
      if (cfg_xfer) begin
        limit_q <= cfg_data_i;
        held_q  <= DepthW'(1);
        for (int i = 0; i < NUM_PRIMES; i++) begin
          masks_q[i] <= MaskW'(1);
        end
      end else if (exec_en) begin
        held_q  <= held_d;
        masks_q <= masks_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= in_data_i.command;
      offset_q <= in_data_i.offset;
      quo_q    <= quo_d;
    end
    if (exec_en) begin
      res_q <= res_c;
    end
    if (out_load) begin
      out_data_q <= res_sel;
    end
  end

  // snapshot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= masks_q;
    end
    if (in_xfer) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/prat_checker.sv
// ----------------------------------------------------------------------------
// prat_checker
// Port-level checks of the residue tracker, bound to the top level.
// ----------------------------------------------------------------------------
module prat_checker #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input prat_pkg::out_item_t  out_data_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);
  import prat_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // depth stays within the stack
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.depth >= 7'd1 && out_data_o.depth <= 7'(MAX_DEPTH))
    else $error("depth out of range");

  // error codes agree with depth
  a_status_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status != StatEmpty || out_data_o.depth == 7'd1) &&
      (out_data_o.status != StatStackFull || out_data_o.depth == 7'(MAX_DEPTH)))
    else $error("status does not match depth");

  // register write and input transfer never share an edge
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o && in_valid_i && !in_stall_o))
    else $error("register write during input transfer");

endmodule

bind prime_residue_admissibility_tracker prat_checker #(
  .MAX_DEPTH(MAX_DEPTH)
) u_prat_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o)
);

// File: tb/prat_result_checker.sv
// ----------------------------------------------------------------------------
// prat_result_checker
// Watches the input, result and configuration channels of the prime residue
// admissibility tracker, predicts status and depth for every input transfer
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module prat_result_checker #(
  parameter int unsigned MAX_DEPTH  = 64,
  parameter int unsigned NUM_PRIMES = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  prat_pkg::in_item_t          in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  prat_pkg::out_item_t         out_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [prat_pkg::LimitW-1:0] cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import prat_pkg::*;

  // predicted state of the block
  logic [63:0]       cov_masks [NUM_PRIMES];
  logic [63:0]       snapshot_stack [MAX_DEPTH][NUM_PRIMES];
  int unsigned       held_cnt;
  logic [LimitW-1:0] prime_limit_q;

  out_item_t   expected_results [$];
  out_item_t   oldest_res;
  out_item_t   new_res;
  int unsigned fail_cnt;
  int unsigned pending_cnt;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  // number of table primes not above the limit
  function automatic int unsigned tracked_primes(logic [LimitW-1:0] lim);
    int unsigned n;
    n = 0;
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (PrimeTable[i] <= lim) n = i + 1;
    end
    return n;
  endfunction

  // back to offset zero alone
  task automatic restart_masks();
    for (int i = 0; i < NUM_PRIMES; i++) cov_masks[i] = 64'd1;
    held_cnt = 1;
  endtask

  // advance the predicted state by one command and form its result
  task automatic apply_command(input in_item_t it, output out_item_t res);
    logic [63:0]        next_masks [NUM_PRIMES];
    logic [63:0]        bitv;
    logic [63:0]        full;
    int unsigned        n;
    int unsigned        q;
    int unsigned        r;
    logic               ok;
    logic [StatusW-1:0] stat;
    stat = StatDone;
    case (it.command)
      CmdRestart: begin
        restart_masks();
      end
      CmdPush: begin
        if (held_cnt >= MAX_DEPTH) begin
          stat = StatStackFull;
        end else begin
          n  = tracked_primes(prime_limit_q);
          ok = 1'b1;
          for (int i = 0; i < NUM_PRIMES; i++) next_masks[i] = cov_masks[i];
          for (int i = 0; i < NUM_PRIMES; i++) begin
            if (ok && i < n) begin
              q    = PrimeTable[i];
              r    = it.offset % q;
              bitv = 64'd1 << r;
              full = (64'd1 << q) - 64'd1;
              // only a newly set bit can complete a mask
              if ((next_masks[i] & bitv) == 64'd0) begin
                next_masks[i] = next_masks[i] | bitv;
                if (next_masks[i] == full) ok = 1'b0;
              end
            end
          end
          if (ok) begin
            for (int i = 0; i < NUM_PRIMES; i++) begin
              snapshot_stack[held_cnt-1][i] = cov_masks[i];
              cov_masks[i] = next_masks[i];
            end
            held_cnt++;
          end else begin
            stat = StatRejected;
          end
        end
      end
      CmdPop: begin
        if (held_cnt <= 1) begin
          stat = StatEmpty;
        end else begin
          for (int i = 0; i < NUM_PRIMES; i++) cov_masks[i] = snapshot_stack[held_cnt-2][i];
          held_cnt--;
        end
      end
      default: begin
      end
    endcase
    res.status = stat;
    res.depth  = held_cnt[DepthW-1:0];
  endtask

  // compare results, track register writes, predict accepted inputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_limit_q = LimitReset;
      restart_masks();
      expected_results.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("unexpected result: status %0d depth %0d",
                     out_data_i.status, out_data_i.depth);
          end
          fail_cnt++;
        end else begin
          oldest_res = expected_results.pop_front();
          if (out_data_i.status !== oldest_res.status ||
              out_data_i.depth !== oldest_res.depth) begin
            if (fail_cnt < 10) begin
              $display("result mismatch: expected status %0d depth %0d, got status %0d depth %0d",
                       oldest_res.status, oldest_res.depth,
                       out_data_i.status, out_data_i.depth);
            end
            fail_cnt++;
          end
        end
      end
      // a register write also restarts from offset zero
      if (cfg_valid_i && cfg_ready_i) begin
        prime_limit_q = cfg_data_i;
        restart_masks();
      end
      if (in_valid_i && !in_stall_i) begin
        apply_command(in_data_i, new_res);
        expected_results.push_back(new_res);
      end
      pending_cnt = expected_results.size();
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the prime residue admissibility tracker: directed
// commands at the reset limit, then random command streams under a range of
// prime limits with random idling on both channels, one long receiver hold
// and a drain before every register write.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prat_pkg::*;

  localparam int unsigned MaxDepth   = 64;
  localparam int unsigned NumPrimes  = 18;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseItems = 128;
  localparam int unsigned PoolSize   = 16;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // prime limits per phase; the last two are replaced by random values
  localparam int unsigned PhaseLimits [NumPhases] = '{
    0, 2, 1023, 61, 1, 3, 512, 13, 60, 62, 0, 0
  };

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LimitW-1:0] cfg_data  = '0;

  int unsigned fail_count;
  int unsigned pending;

  // idling control shared by the sender and the receiver
  logic hold_req = 1'b0;
  logic calm     = 1'b0;

  // offsets offered in the current sequence, re-offered to build depth
  logic [OffsetW-1:0] offset_pool [$];
  logic               push_heavy;

  prime_residue_admissibility_tracker #(
    .MAX_DEPTH  (MaxDepth),
    .NUM_PRIMES (NumPrimes)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  prat_result_checker #(
    .MAX_DEPTH  (MaxDepth),
    .NUM_PRIMES (NumPrimes)
  ) chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("prime_residue_admissibility_tracker verification failed");
    $finish;
  end

  // offer one item and hold it until its transfer
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [OffsetW-1:0] off);
    in_valid       <= 1'b1;
    in_data.command <= cmd;
    in_data.offset  <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random sender gap after a transfer
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_limit(input logic [LimitW-1:0] lim);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    offset_pool.delete();
    @(posedge clk);
  endtask

  // candidate offset, biased toward values that keep masks open
  function automatic logic [OffsetW-1:0] pick_offset();
    logic [OffsetW-1:0] off;
    case ($urandom_range(0, 3))
      0:       off = OffsetW'($urandom_range(0, 511));
      1:       off = OffsetW'(2 * $urandom_range(0, 255));
      2:       off = OffsetW'(6 * $urandom_range(0, 85));
      default: off = OffsetW'(30 * $urandom_range(0, 17));
    endcase
    return off;
  endfunction

  // one random command of the current sequence
  task automatic send_random();
    int unsigned        roll;
    int unsigned        push_w;
    logic [OffsetW-1:0] off;
    roll   = $urandom_range(0, 99);
    push_w = push_heavy ? 70 : 25;
    off    = OffsetW'($urandom_range(0, 511));
    if (roll < push_w) begin
      if (offset_pool.size() != 0 && $urandom_range(0, 1) == 0) begin
        off = offset_pool[$urandom_range(0, offset_pool.size() - 1)];
      end else begin
        off = pick_offset();
        if (offset_pool.size() < PoolSize) offset_pool.push_back(off);
      end
      send_item(CmdPush, off);
    end else if (roll < 88) begin
      send_item(CmdPop, off);
    end else if (roll < 94) begin
      offset_pool.delete();
      send_item(CmdRestart, off);
    end else begin
      send_item(CmdUnused, off);
    end
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [LimitW-1:0] lim;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands at the reset limit
    send_item(CmdPop, 9'd0);        // nothing to pop
    send_item(CmdUnused, 9'd511);   // unused command
    send_item(CmdPush, 9'd0);       // already covered residues
    send_item(CmdPush, 9'd1);       // completes the mask of two
    send_item(CmdPush, 9'd511);
    send_item(CmdPush, 9'd2);
    send_item(CmdPush, 9'd4);       // completes the mask of three
    send_item(CmdPush, 9'd6);
    send_item(CmdPop, 9'd511);
    send_item(CmdPush, 9'd4);
    send_item(CmdPop, 9'd0);
    send_item(CmdPop, 9'd0);
    send_item(CmdPop, 9'd0);
    send_item(CmdRestart, 9'd511);  // offset ignored
    send_item(CmdPush, 9'd510);
    send_item(CmdPush, 9'd0);
    send_item(CmdPush, 9'd510);
    send_item(CmdRestart, 9'd0);
    send_item(CmdPush, 9'd3);
    send_item(CmdPush, 9'd258);
    send_item(CmdPush, 9'd60);
    send_item(CmdPush, 9'd120);
    send_item(CmdPop, 9'd0);
    send_item(CmdUnused, 9'd0);
    send_item(CmdRestart, 9'd0);

    // random phases, one prime limit each
    for (int p = 0; p < NumPhases; p++) begin
      lim = (p >= NumPhases - 2) ? LimitW'($urandom_range(0, 1023))
                                 : LimitW'(PhaseLimits[p]);
      write_limit(lim);
      calm = (p == NumPhases - 1);
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 24 == 0) push_heavy = ($urandom_range(0, 2) != 0);
        // long receiver hold while the sender keeps offering
        if (p == 2 && k == 10) hold_req = 1'b1;
        send_random();
        sender_gap();
      end
    end

    // wait out the last results
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("prime_residue_admissibility_tracker verification clean");
    end else begin
      $display("prime_residue_admissibility_tracker verification failed");
    end
    $finish;
  end

endmodule

// File: prime_residue_admissibility_tracker.f
rtl/prat_pkg.sv
rtl/prime_residue_admissibility_tracker.sv
rtl/prat_checker.sv
tb/prat_result_checker.sv
tb/tb.sv
